/* design/tife_pkg.sv */
// ----------------------------------------------------------------------------
// tife_pkg
// Types and constants shared by the tagged integer field encoder.
// ----------------------------------------------------------------------------
package tife_pkg;

    localparam int FRAME_MAX = 10;
    localparam int LEN_W     = 4;

    // field kinds
    localparam logic [1:0] CMD_INT  = 2'd0;
    localparam logic [1:0] CMD_BOOL = 2'd1;
    localparam logic [1:0] CMD_STR  = 2'd2;

    // header type codes
    localparam logic [3:0] TY_BYTE  = 4'd0;
    localparam logic [3:0] TY_SHORT = 4'd1;
    localparam logic [3:0] TY_INT   = 4'd2;
    localparam logic [3:0] TY_LONG  = 4'd3;
    localparam logic [3:0] TY_STR1  = 4'd6;
    localparam logic [3:0] TY_STR4  = 4'd7;
    localparam logic [3:0] TY_ZERO  = 4'd12;

    localparam logic [3:0] TAG_EXT    = 4'hF;
    localparam logic [7:0] TAG_LIMIT  = 8'd15;
    localparam logic [26:0] STR1_MAX  = 27'd255;

    localparam logic signed [63:0] I8_MIN  = -64'sd128;
    localparam logic signed [63:0] I8_MAX  = 64'sd127;
    localparam logic signed [63:0] I16_MIN = -64'sd32768;
    localparam logic signed [63:0] I16_MAX = 64'sd32767;
    localparam logic signed [63:0] I32_MIN = -64'sd2147483648;
    localparam logic signed [63:0] I32_MAX = 64'sd2147483647;

    typedef struct packed {
        logic [1:0]         command;
        logic [7:0]         tag;
        logic signed [63:0] value;
        logic               present;
        logic signed [31:0] default_value;
        logic               forced;
        logic [26:0]        string_length;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } out_item_t;

    typedef logic [0:FRAME_MAX-1][7:0] frame_bytes_t;

    typedef struct packed {
        frame_bytes_t     bytes;
        logic [LEN_W-1:0] len;
    } frame_t;

endpackage

/* design/tife_encode.sv */
// ----------------------------------------------------------------------------
// tife_encode
// Builds the full byte frame of one field: tag header plus narrowest value.
// ----------------------------------------------------------------------------
module tife_encode
(
    input  tife_pkg::in_item_t item,
    output tife_pkg::frame_t   frame
);
    import tife_pkg::*;

    logic signed [63:0] def64;
    logic signed [63:0] n;
    logic               emit;
    logic               is_str;
    logic [26:0]        slen;
    logic               dflt_true;
    logic               val_true;
    logic [3:0]         ty;
    logic [3:0]         nb;
    logic [63:0]        pv;
    logic [63:0]        aligned;
    logic [7:0]         h0;
    logic               two_hdr;
    logic [79:0]        vec;

    assign def64     = {{32{item.default_value[31]}}, item.default_value};
    assign dflt_true = (item.default_value != 32'sd0);
    assign val_true  = (item.value != 64'sd0);

    always_comb
    begin
        emit   = 1'b0;
        is_str = 1'b0;
        n      = 64'sd0;
        slen   = 27'd0;
        unique case (item.command)
            CMD_INT:
            begin
                if (item.present)
                begin
                    emit = (item.value != def64);
                    n    = item.value;
                end
                else
                begin
                    emit = item.forced;
                    n    = def64;
                end
            end
            CMD_BOOL:
            begin
                if (item.present)
                begin
                    emit = (val_true != dflt_true);
                    n    = {63'd0, val_true};
                end
                else
                begin
                    emit = item.forced;
                    n    = {63'd0, dflt_true};
                end
            end
            CMD_STR:
            begin
                is_str = 1'b1;
                emit   = item.present || item.forced;
                slen   = item.present ? item.string_length : 27'd0;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (is_str)
        begin
            pv = {37'd0, slen};
            if (slen > STR1_MAX)
            begin
                ty = TY_STR4;
                nb = 4'd4;
            end
            else
            begin
                ty = TY_STR1;
                nb = 4'd1;
            end
        end
        else
        begin
            pv = n;
            if (n == 64'sd0)
            begin
                ty = TY_ZERO;
                nb = 4'd0;
            end
            else if (n >= I8_MIN && n <= I8_MAX)
            begin
                ty = TY_BYTE;
                nb = 4'd1;
            end
            else if (n >= I16_MIN && n <= I16_MAX)
            begin
                ty = TY_SHORT;
                nb = 4'd2;
            end
            else if (n >= I32_MIN && n <= I32_MAX)
            begin
                ty = TY_INT;
                nb = 4'd4;
            end
            else
            begin
                ty = TY_LONG;
                nb = 4'd8;
            end
        end
    end

    // left-align the value bytes, big-endian
    always_comb
    begin
        case (nb)
            4'd1:    aligned = {pv[7:0], 56'd0};
            4'd2:    aligned = {pv[15:0], 48'd0};
            4'd4:    aligned = {pv[31:0], 32'd0};
            4'd8:    aligned = pv;
            default: aligned = 64'd0;
        endcase
    end

    assign two_hdr = (item.tag >= TAG_LIMIT);
    assign h0      = two_hdr ? {TAG_EXT, ty} : {item.tag[3:0], ty};
    assign vec     = two_hdr ? {h0, item.tag, aligned} : {h0, aligned, 8'd0};

    assign frame.bytes = frame_bytes_t'(vec);
    assign frame.len   = emit ? (two_hdr ? 4'd2 : 4'd1) + nb : 4'd0;

endmodule

/* design/tife_serializer.sv */
// ----------------------------------------------------------------------------
// tife_serializer
// Holds one encoded frame and sends it out one byte per transfer.
// ----------------------------------------------------------------------------
module tife_serializer
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                frame_valid,
    input  tife_pkg::frame_t    frame,
    output logic                frame_ready,
    output logic                dst_valid,
    input  logic                dst_stall,
    output tife_pkg::out_item_t dst_data
);
    import tife_pkg::*;

    logic             busy_reg;
    logic             busy_next;
    frame_t           frame_reg;
    frame_t           frame_next;
    logic [LEN_W-1:0] idx_reg;
    logic [LEN_W-1:0] idx_next;
    logic             dst_valid_reg;
    logic             dst_valid_next;
    out_item_t        dst_data_reg;
    out_item_t        dst_data_next;

    logic out_free;
    logic send;
    logic final_byte;
    logic load;

    assign out_free    = !dst_valid_reg || !dst_stall;
    assign send        = busy_reg && out_free;
    assign final_byte  = send && (idx_reg == frame_reg.len - 4'd1);
    assign frame_ready = !busy_reg || final_byte;
    assign load        = frame_valid && frame_ready;

    always_comb
    begin
        busy_next      = busy_reg;
        frame_next     = frame_reg;
        idx_next       = idx_reg;
        dst_valid_next = dst_valid_reg;
        dst_data_next  = dst_data_reg;
        if (send)
        begin
            dst_valid_next         = 1'b1;
            dst_data_next.out_byte = frame_reg.bytes[idx_reg];
            dst_data_next.last     = final_byte;
            idx_next               = idx_reg + 4'd1;
        end
        else if (out_free)
        begin
            dst_valid_next = 1'b0;
        end
        if (final_byte)
        begin
            busy_next = 1'b0;
        end
        if (load)
        begin
            busy_next  = 1'b1;
            frame_next = frame;
            idx_next   = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            dst_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            dst_valid_reg <= dst_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg    <= frame_next;
        dst_data_reg <= dst_data_next;
    end

    assign dst_valid = dst_valid_reg;
    assign dst_data  = dst_data_reg;

endmodule

/* design/tagged_integer_field_encoder_top.sv */
// ----------------------------------------------------------------------------
// tagged_integer_field_encoder_top
// Encodes one tagged scalar field per input transfer into a byte stream.
// Path: input register, serializer frame register, output data register;
// stalls can hold a field in any. Throughput: one output byte per cycle
// while dst_stall is low, set by the byte-wide output register; a frame is
// 1 to 10 bytes. Suppressed fields produce no output and bypass the serializer.
// Reset: asynchronous active-low rst_n clears all valid flags; no data lost
// other than items in flight.
// ----------------------------------------------------------------------------
module tagged_integer_field_encoder_top
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    output logic                src_stall,
    input  tife_pkg::in_item_t  src_data,
    output logic                dst_valid,
    input  logic                dst_stall,
    output tife_pkg::out_item_t dst_data
);
    import tife_pkg::*;

    logic     in_valid_reg;
    logic     in_valid_next;
    in_item_t in_item_reg;
    in_item_t in_item_next;

    frame_t frame;
    logic   frame_ready;
    logic   frame_empty;
    logic   take;
    logic   accept;

    tife_encode u_encode
    (
        .item  (in_item_reg),
        .frame (frame)
    );

    assign frame_empty = (frame.len == 4'd0);
    assign take        = in_valid_reg && (frame_empty || frame_ready);
    assign src_stall   = in_valid_reg && !take;
    assign accept      = src_valid && !src_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        if (take)
        begin
            in_valid_next = 1'b0;
        end
        if (accept)
        begin
            in_valid_next = 1'b1;
            in_item_next  = src_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg <= in_item_next;
    end

    tife_serializer u_serializer
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (in_valid_reg && !frame_empty),
        .frame       (frame),
        .frame_ready (frame_ready),
        .dst_valid   (dst_valid),
        .dst_stall   (dst_stall),
        .dst_data    (dst_data)
    );

endmodule
